### rtl/core/tscw_pkg.sv
package tscw_pkg;

   localparam int COLS_DEFAULT = 40;
   localparam int ROWS_DEFAULT = 24;

   // command codes
   localparam logic [2:0] FUNC_PUT_CONV = 3'd0;
   localparam logic [2:0] FUNC_PUT_RAW  = 3'd1;
   localparam logic [2:0] FUNC_GOTO     = 3'd2;
   localparam logic [2:0] FUNC_CLEAR    = 3'd3;
   localparam logic [2:0] FUNC_READ     = 3'd4;

   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_CR      = 8'd13;
   localparam logic [7:0] INV_BIT      = 8'h80;

   // microprogram steps
   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_WRITE = 4'd2;
   localparam logic [3:0] S_NL    = 4'd3;
   localparam logic [3:0] S_SC_RD = 4'd4;
   localparam logic [3:0] S_SC_WR = 4'd5;
   localparam logic [3:0] S_BOT   = 4'd6;
   localparam logic [3:0] S_GOTO  = 4'd7;
   localparam logic [3:0] S_CLR   = 4'd8;
   localparam logic [3:0] S_RD    = 4'd9;
   localparam logic [3:0] S_RESP  = 4'd10;

   // memory operations
   localparam logic [2:0] MEM_NONE    = 3'd0;
   localparam logic [2:0] MEM_ZERO    = 3'd1;
   localparam logic [2:0] MEM_CHAR    = 3'd2;
   localparam logic [2:0] MEM_RD_NEXT = 3'd3;
   localparam logic [2:0] MEM_COPY    = 3'd4;
   localparam logic [2:0] MEM_RD_CELL = 3'd5;

   // address counter operations
   localparam logic [1:0] ADDR_HOLD = 2'd0;
   localparam logic [1:0] ADDR_ZERO = 2'd1;
   localparam logic [1:0] ADDR_INC  = 2'd2;

   // cursor operations
   localparam logic [2:0] CUR_HOLD    = 3'd0;
   localparam logic [2:0] CUR_ADVANCE = 3'd1;
   localparam logic [2:0] CUR_NEWLINE = 3'd2;
   localparam logic [2:0] CUR_GOTO    = 3'd3;
   localparam logic [2:0] CUR_HOME    = 3'd4;

   // jump conditions
   localparam logic [2:0] COND_ALWAYS    = 3'd0;
   localparam logic [2:0] COND_ADDR_LAST = 3'd1;
   localparam logic [2:0] COND_COPY_LAST = 3'd2;
   localparam logic [2:0] COND_COL_LAST  = 3'd3;
   localparam logic [2:0] COND_ROW_LAST  = 3'd4;
   localparam logic [2:0] COND_OUT_FREE  = 3'd5;
   localparam logic [2:0] COND_DISPATCH  = 3'd6;

   typedef struct packed {
      logic       accept;
      logic       rsp_load;
      logic [2:0] mem_op;
      logic [1:0] addr_op;
      logic [2:0] cur_op;
      logic [2:0] cond;
      logic [3:0] t_true;
      logic [3:0] t_false;
   } tscw_ctl_type;

   typedef struct packed {
      logic       addr_last;
      logic       copy_last;
      logic       col_last;
      logic       row_last;
      logic [2:0] req_func;
      logic       req_nl;
   } tscw_dp_status_type;

   typedef struct packed {
      tscw_dp_status_type dp;
      logic               req_take;
      logic               out_free;
   } tscw_seq_status_type;

   function automatic tscw_ctl_type cw(input logic acc, input logic rl,
                                       input logic [2:0] mem, input logic [1:0] addr,
                                       input logic [2:0] cur, input logic [2:0] cond,
                                       input logic [3:0] tt, input logic [3:0] tf);
      tscw_ctl_type w;
      w.accept   = acc;
      w.rsp_load = rl;
      w.mem_op   = mem;
      w.addr_op  = addr;
      w.cur_op   = cur;
      w.cond     = cond;
      w.t_true   = tt;
      w.t_false  = tf;
      return w;
   endfunction

   // control store
   function automatic tscw_ctl_type ucode(input logic [3:0] step);
      tscw_ctl_type w;
      case (step)
         S_INIT:  w = cw(1'b0, 1'b0, MEM_ZERO, ADDR_INC, CUR_HOLD, COND_ADDR_LAST,
                         S_IDLE, S_INIT);
         S_IDLE:  w = cw(1'b1, 1'b0, MEM_NONE, ADDR_ZERO, CUR_HOLD, COND_DISPATCH,
                         S_IDLE, S_IDLE);
         S_WRITE: w = cw(1'b0, 1'b0, MEM_CHAR, ADDR_HOLD, CUR_ADVANCE, COND_COL_LAST,
                         S_NL, S_RESP);
         S_NL:    w = cw(1'b0, 1'b0, MEM_NONE, ADDR_HOLD, CUR_NEWLINE, COND_ROW_LAST,
                         S_SC_RD, S_RESP);
         S_SC_RD: w = cw(1'b0, 1'b0, MEM_RD_NEXT, ADDR_HOLD, CUR_HOLD, COND_ALWAYS,
                         S_SC_WR, S_SC_WR);
         S_SC_WR: w = cw(1'b0, 1'b0, MEM_COPY, ADDR_INC, CUR_HOLD, COND_COPY_LAST,
                         S_BOT, S_SC_RD);
         S_BOT:   w = cw(1'b0, 1'b0, MEM_ZERO, ADDR_INC, CUR_HOLD, COND_ADDR_LAST,
                         S_RESP, S_BOT);
         S_GOTO:  w = cw(1'b0, 1'b0, MEM_NONE, ADDR_HOLD, CUR_GOTO, COND_ALWAYS,
                         S_RESP, S_RESP);
         S_CLR:   w = cw(1'b0, 1'b0, MEM_ZERO, ADDR_INC, CUR_HOME, COND_ADDR_LAST,
                         S_RESP, S_CLR);
         S_RD:    w = cw(1'b0, 1'b0, MEM_RD_CELL, ADDR_HOLD, CUR_HOLD, COND_ALWAYS,
                         S_RESP, S_RESP);
         S_RESP:  w = cw(1'b0, 1'b1, MEM_NONE, ADDR_HOLD, CUR_HOLD, COND_OUT_FREE,
                         S_IDLE, S_RESP);
         default: w = cw(1'b0, 1'b0, MEM_NONE, ADDR_HOLD, CUR_HOLD, COND_ALWAYS,
                         S_IDLE, S_IDLE);
      endcase
      return w;
   endfunction

   // entry step of each command
   function automatic logic [3:0] dispatch_step(input logic [2:0] func, input logic is_nl);
      logic [3:0] s;
      case (func)
         FUNC_PUT_CONV, FUNC_PUT_RAW: s = is_nl ? S_NL : S_WRITE;
         FUNC_GOTO:                   s = S_GOTO;
         FUNC_CLEAR:                  s = S_CLR;
         FUNC_READ:                   s = S_RD;
         default:                     s = S_RESP;
      endcase
      return s;
   endfunction

endpackage

### rtl/core/tscw_cell_mem.sv
module tscw_cell_mem #(
   parameter int DEPTH = tscw_pkg::COLS_DEFAULT * tscw_pkg::ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [7:0]               wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [7:0]               rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/tscw_seq.sv
module tscw_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  tscw_pkg::tscw_seq_status_type status,
   output tscw_pkg::tscw_ctl_type       ctl
);

   logic [3:0] pc_ff;
   logic [3:0] pc_in;
   logic       taken;

   always_comb begin
      ctl = tscw_pkg::ucode(pc_ff);
      case (ctl.cond)
         tscw_pkg::COND_ALWAYS:    taken = 1'b1;
         tscw_pkg::COND_ADDR_LAST: taken = status.dp.addr_last;
         tscw_pkg::COND_COPY_LAST: taken = status.dp.copy_last;
         tscw_pkg::COND_COL_LAST:  taken = status.dp.col_last;
         tscw_pkg::COND_ROW_LAST:  taken = status.dp.row_last;
         tscw_pkg::COND_OUT_FREE:  taken = status.out_free;
         default:                  taken = 1'b0;
      endcase
      if (ctl.cond == tscw_pkg::COND_DISPATCH && status.req_take) begin
         pc_in = tscw_pkg::dispatch_step(status.dp.req_func, status.dp.req_nl);
      end else begin
         pc_in = taken ? ctl.t_true : ctl.t_false;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tscw_pkg::S_INIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

### rtl/core/tscw_datapath.sv
module tscw_datapath #(
   parameter int COLS = tscw_pkg::COLS_DEFAULT,
   parameter int ROWS = tscw_pkg::ROWS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tscw_pkg::tscw_ctl_type      ctl,
   input  logic                        req_take,
   input  logic [2:0]                  req_func,
   input  logic [7:0]                  req_char_code,
   input  logic [5:0]                  req_target_col,
   input  logic [4:0]                  req_target_row,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   output tscw_pkg::tscw_dp_status_type status,
   output logic [5:0]                  cursor_col,
   output logic [4:0]                  cursor_row,
   output logic [7:0]                  cell_data
);

   localparam int DEPTH = COLS * ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam int TCW   = (CW > 6) ? CW : 6;
   localparam int TRW   = (RW > 5) ? RW : 5;
   localparam logic [AW-1:0] COLS_A = AW'(COLS);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          inverse_ff;
   logic [2:0]    func_ff;
   logic [7:0]    char_ff;
   logic [CW-1:0] tc_ff;
   logic [RW-1:0] tr_ff;

   logic [7:0]    eff_code;
   logic [TCW-1:0] tc_ext;
   logic [TRW-1:0] tr_ext;
   logic [CW-1:0] tc_sat;
   logic [RW-1:0] tr_sat;
   logic [AW-1:0] cur_addr;
   logic [AW-1:0] tgt_addr;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata;

   function automatic logic [7:0] convert_code(input logic [7:0] c);
      logic [7:0] r;
      if (c == tscw_pkg::CODE_CR) begin
         r = tscw_pkg::CODE_NEWLINE;
      end else if (c < 8'd32) begin
         r = c + 8'd64;
      end else if (c < 8'd96) begin
         r = c - 8'd32;
      end else begin
         r = c;
      end
      return r;
   endfunction

   // request decode, straight from the ports
   always_comb begin
      eff_code = (req_func == tscw_pkg::FUNC_PUT_CONV) ? convert_code(req_char_code)
                                                       : req_char_code;
      tc_ext = TCW'(req_target_col);
      tr_ext = TRW'(req_target_row);
      tc_sat = (tc_ext > TCW'(COLS - 1)) ? CW'(COLS - 1) : CW'(tc_ext);
      tr_sat = (tr_ext > TRW'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(tr_ext);
   end

   assign status.req_func  = req_func;
   assign status.req_nl    = (req_func == tscw_pkg::FUNC_PUT_CONV ||
                              req_func == tscw_pkg::FUNC_PUT_RAW) &&
                             (eff_code == tscw_pkg::CODE_NEWLINE);
   assign status.addr_last = (addr_ff == AW'(DEPTH - 1));
   assign status.copy_last = (addr_ff == AW'(DEPTH - COLS - 1));
   assign status.col_last  = (col_ff == CW'(COLS - 1));
   assign status.row_last  = (row_ff == RW'(ROWS - 1));

   assign cur_addr = AW'(row_ff) * COLS_A + AW'(col_ff);
   assign tgt_addr = AW'(tr_ff) * COLS_A + AW'(tc_ff);

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_func;
         char_ff <= eff_code;
         tc_ff   <= tc_sat;
         tr_ff   <= tr_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff <= 1'b0;
      end else if (csr_we) begin
         inverse_ff <= csr_wdata;
      end
   end

   // memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = addr_ff;
      mem_raddr = addr_ff + COLS_A;
      mem_wdata = 8'd0;
      case (ctl.mem_op)
         tscw_pkg::MEM_ZERO: begin
            mem_we = 1'b1;
         end
         tscw_pkg::MEM_CHAR: begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = inverse_ff ? (char_ff | tscw_pkg::INV_BIT) : char_ff;
         end
         tscw_pkg::MEM_RD_NEXT: begin
            mem_re = 1'b1;
         end
         tscw_pkg::MEM_COPY: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
         end
         tscw_pkg::MEM_RD_CELL: begin
            mem_re    = 1'b1;
            mem_raddr = tgt_addr;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (ctl.addr_op)
         tscw_pkg::ADDR_ZERO: addr_in = '0;
         tscw_pkg::ADDR_INC:  addr_in = addr_ff + AW'(1);
         default:             addr_in = addr_ff;
      endcase
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      case (ctl.cur_op)
         tscw_pkg::CUR_ADVANCE: begin
            col_in = col_ff + CW'(1);
         end
         tscw_pkg::CUR_NEWLINE: begin
            col_in = '0;
            row_in = status.row_last ? row_ff : row_ff + RW'(1);
         end
         tscw_pkg::CUR_GOTO: begin
            col_in = tc_ff;
            row_in = tr_ff;
         end
         tscw_pkg::CUR_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         default: begin
            col_in = col_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         addr_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         addr_ff <= addr_in;
      end
   end

   tscw_cell_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign cursor_col = 6'(col_ff);
   assign cursor_row = 5'(row_ff);
   assign cell_data  = (func_ff == tscw_pkg::FUNC_READ) ? mem_rdata : 8'd0;

endmodule

### rtl/core/text_screen_char_writer_top.sv
// channel  dir  handshake             beat contents
// req      in   req_valid, req_stall  req_func, req_char_code, req_target_col, req_target_row
// rsp      out  rsp_valid, rsp_stall  rsp_cursor_col, rsp_cursor_row, rsp_cell_data
// csr      in   csr_we                csr_wdata (inverse_on)
//
// one command at a time, run by the microprogram sequencer over the two-port cell memory.
// a scroll copies the screen up one row, each cell read then written, and zeroes the bottom row.
// clear zeroes all COLS*ROWS cells; after reset a zeroing pass over all cells runs first.
// a result held by rsp_stall keeps the sequencer at its result step; the next req beat
// is taken once that result has been handed to the output register.
module text_screen_char_writer_top #(
   parameter int COLS = tscw_pkg::COLS_DEFAULT,
   parameter int ROWS = tscw_pkg::ROWS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic [5:0] req_target_col,
   input  logic [4:0] req_target_row,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_cursor_col,
   output logic [4:0] rsp_cursor_row,
   output logic [7:0] rsp_cell_data,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   tscw_pkg::tscw_ctl_type        ctl;
   tscw_pkg::tscw_dp_status_type  dp_status;
   tscw_pkg::tscw_seq_status_type seq_status;

   logic       req_take;
   logic       out_free;
   logic [5:0] cursor_col;
   logic [4:0] cursor_row;
   logic [7:0] cell_data;

   logic       rsp_valid_ff;
   logic [5:0] rsp_col_ff;
   logic [4:0] rsp_row_ff;
   logic [7:0] rsp_data_ff;

   assign req_stall = !ctl.accept;
   assign req_take  = req_valid && ctl.accept;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign seq_status.dp       = dp_status;
   assign seq_status.req_take = req_take;
   assign seq_status.out_free = out_free;

   tscw_seq u_seq (
      .clock (clock),
      .reset (reset),
      .status(seq_status),
      .ctl   (ctl)
   );

   tscw_datapath #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .req_take      (req_take),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .req_target_col(req_target_col),
      .req_target_row(req_target_row),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .status        (dp_status),
      .cursor_col    (cursor_col),
      .cursor_row    (cursor_row),
      .cell_data     (cell_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load && out_free) begin
         rsp_col_ff  <= cursor_col;
         rsp_row_ff  <= cursor_row;
         rsp_data_ff <= cell_data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_data  = rsp_data_ff;

endmodule

### bench/text_screen_char_writer_checker.sv
`timescale 1ns / 1ps
module text_screen_char_writer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic [5:0] req_target_col,
   input  logic [4:0] req_target_row,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [5:0] rsp_cursor_col,
   input  logic [4:0] rsp_cursor_row,
   input  logic [7:0] rsp_cell_data,
   input  logic       csr_we,
   input  logic       csr_wdata,
   output int         fail_count,
   output int         pending
);

   localparam int NCOLS  = tscw_pkg::COLS_DEFAULT;
   localparam int NROWS  = tscw_pkg::ROWS_DEFAULT;
   localparam int NCELLS = NCOLS * NROWS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [5:0] col;
      logic [4:0] row;
      logic [7:0] data;
   } cursor_report_type;

   logic [7:0]        screen [NCELLS];
   logic [5:0]        cur_col;
   logic [4:0]        cur_row;
   logic              inverse;
   cursor_report_type expected_reports [$];
   cursor_report_type want;
   cursor_report_type got;

   function automatic logic [7:0] convert_char(input logic [7:0] c);
      if (c == tscw_pkg::CODE_CR) return tscw_pkg::CODE_NEWLINE;
      if (c < 8'd32) return c + 8'd64;
      if (c < 8'd96) return c - 8'd32;
      return c;
   endfunction

   function automatic void wipe_screen();
      for (int i = 0; i < NCELLS; i++) screen[i] = '0;
   endfunction

   // on the bottom row a newline scrolls everything up one row
   function automatic void next_line();
      cur_col = '0;
      if (cur_row == 5'(NROWS - 1)) begin
         for (int i = 0; i < NCELLS - NCOLS; i++) screen[i] = screen[i + NCOLS];
         for (int i = NCELLS - NCOLS; i < NCELLS; i++) screen[i] = '0;
      end else begin
         cur_row = cur_row + 5'd1;
      end
   endfunction

   function automatic void put_char(input logic [7:0] c);
      if (c == tscw_pkg::CODE_NEWLINE) begin
         next_line();
         return;
      end
      screen[int'(cur_row) * NCOLS + int'(cur_col)] = inverse ? (c | tscw_pkg::INV_BIT) : c;
      if (cur_col == 6'(NCOLS - 1)) next_line();
      else cur_col = cur_col + 6'd1;
   endfunction

   function automatic int clamp(input int v, input int lim);
      return (v > lim - 1) ? lim - 1 : v;
   endfunction

   function automatic cursor_report_type run_command(input logic [2:0] f, input logic [7:0] c,
                                                     input logic [5:0] tc,
                                                     input logic [4:0] tr);
      cursor_report_type r;
      int col;
      int row;
      col = clamp(int'(tc), NCOLS);
      row = clamp(int'(tr), NROWS);
      r.data = '0;
      case (f)
         tscw_pkg::FUNC_PUT_CONV: put_char(convert_char(c));
         tscw_pkg::FUNC_PUT_RAW:  put_char(c);
         tscw_pkg::FUNC_GOTO: begin
            cur_col = 6'(col);
            cur_row = 5'(row);
         end
         tscw_pkg::FUNC_CLEAR: begin
            wipe_screen();
            cur_col = '0;
            cur_row = '0;
         end
         tscw_pkg::FUNC_READ: r.data = screen[row * NCOLS + col];
         default: ;
      endcase
      r.col = cur_col;
      r.row = cur_row;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wipe_screen();
         cur_col = '0;
         cur_row = '0;
         inverse = 1'b0;
         expected_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.col  = rsp_cursor_col;
            got.row  = rsp_cursor_row;
            got.data = rsp_cell_data;
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: result beat with nothing expected: col %0d row %0d data %02h",
                           $realtime, got.col, got.row, got.data);
            end else begin
               want = expected_reports.pop_front();
               if (got.col !== want.col || got.row !== want.row || got.data !== want.data) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("%0t: result mismatch: expected col %0d row %0d data %02h, %s",
                              $realtime, want.col, want.row, want.data,
                              $sformatf("got col %0d row %0d data %02h",
                                        got.col, got.row, got.data));
               end
            end
         end
         if (csr_we) inverse = csr_wdata;
         if (req_valid && !req_stall)
            expected_reports.push_back(run_command(req_func, req_char_code,
                                                   req_target_col, req_target_row));
      end
      pending = expected_reports.size();
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 258;
   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FUNC_SPARE_MID   = 3'd6;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_func;
   logic [7:0] req_char_code;
   logic [5:0] req_target_col;
   logic [4:0] req_target_row;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [5:0] rsp_cursor_col;
   logic [4:0] rsp_cursor_row;
   logic [7:0] rsp_cell_data;
   logic       csr_we;
   logic       csr_wdata;

   int fail_count;
   int pending;
   int cycles = 0;
   bit quiet = 1'b0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int text_left = 0;

   text_screen_char_writer_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_target_col (req_target_col),
      .req_target_row (req_target_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_data  (rsp_cell_data),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   text_screen_char_writer_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_target_col (req_target_col),
      .req_target_row (req_target_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_data  (rsp_cell_data),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("text_screen_char_writer_top test failed");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 26);
         end
      end
   end

   task automatic send_cmd(input logic [2:0] f, input logic [7:0] c,
                           input logic [5:0] tc, input logic [4:0] tr);
      while (!quiet && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_char_code  <= c;
      req_target_col <= tc;
      req_target_row <= tr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_inverse(input logic v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // mostly runs of text that wrap and scroll, mixed with single puts, cursor moves, cell reads, clears and spare codes
   task automatic send_random();
      logic [2:0] f;
      logic [7:0] c;
      logic [5:0] tc;
      logic [4:0] tr;
      int pick;
      c  = 8'($urandom_range(255));
      tc = 6'($urandom_range(63));
      tr = 5'($urandom_range(31));
      if (text_left == 0 && $urandom_range(99) < 3) text_left = int'($urandom_range(80, 10));
      if (text_left > 0) begin
         text_left--;
         f = $urandom_range(1) ? tscw_pkg::FUNC_PUT_RAW : tscw_pkg::FUNC_PUT_CONV;
         if ($urandom_range(99) < 4)
            c = (f == tscw_pkg::FUNC_PUT_RAW) ? tscw_pkg::CODE_NEWLINE : tscw_pkg::CODE_CR;
      end else begin
         pick = int'($urandom_range(999));
         if (pick < 300) f = tscw_pkg::FUNC_PUT_CONV;
         else if (pick < 500) f = tscw_pkg::FUNC_PUT_RAW;
         else if (pick < 700) f = tscw_pkg::FUNC_GOTO;
         else if (pick < 712) f = tscw_pkg::FUNC_CLEAR;
         else if (pick < 970) f = tscw_pkg::FUNC_READ;
         else f = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
         if ((f == tscw_pkg::FUNC_GOTO || f == tscw_pkg::FUNC_READ) &&
             $urandom_range(99) < 85) begin
            tc = 6'($urandom_range(39));
            tr = 5'($urandom_range(23));
         end
      end
      send_cmd(f, c, tc, tr);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = tscw_pkg::FUNC_PUT_CONV;
      req_char_code  = '0;
      req_target_col = '0;
      req_target_row = '0;
      csr_we         = 1'b0;
      csr_wdata      = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      write_inverse(1'b0);

      // directed: conversion edges, newline forms, wrap and scroll, saturation, spare codes, clear
      send_cmd(tscw_pkg::FUNC_READ,     8'hff, 6'd63, 5'd31);
      send_cmd(tscw_pkg::FUNC_PUT_CONV, 8'd0,  6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_CONV, 8'd31, 6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_CONV, 8'd32, 6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_CONV, 8'd95, 6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_CONV, 8'd96, 6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_CONV, 8'hff, 6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_CONV, tscw_pkg::CODE_NEWLINE, 6'd0, 5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_CONV, tscw_pkg::CODE_CR, 6'd0, 5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_RAW,  8'd0,  6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_RAW,  8'hff, 6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_RAW,  tscw_pkg::CODE_CR, 6'd0, 5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_RAW,  tscw_pkg::CODE_NEWLINE, 6'd0, 5'd0);
      send_cmd(tscw_pkg::FUNC_READ,     8'd0,  6'd6,  5'd0);
      send_cmd(tscw_pkg::FUNC_GOTO,     8'd0,  6'd38, 5'd23);
      send_cmd(tscw_pkg::FUNC_PUT_RAW,  8'h41, 6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_PUT_RAW,  8'h42, 6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_READ,     8'd0,  6'd38, 5'd22);
      send_cmd(tscw_pkg::FUNC_GOTO,     8'd0,  6'd63, 5'd31);
      send_cmd(tscw_pkg::FUNC_PUT_RAW,  tscw_pkg::CODE_NEWLINE, 6'd0, 5'd0);
      send_cmd(FUNC_SPARE_FIRST,        8'hff, 6'd63, 5'd31);
      send_cmd(FUNC_SPARE_MID,          8'h55, 6'd21, 5'd10);
      send_cmd(FUNC_SPARE_LAST,         8'haa, 6'd42, 5'd21);
      send_cmd(tscw_pkg::FUNC_CLEAR,    8'd0,  6'd0,  5'd0);
      send_cmd(tscw_pkg::FUNC_READ,     8'd0,  6'd39, 5'd21);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         write_inverse(phase % 2 == 0);
         quiet = (phase == 2);
         if (phase == 3) hold_asked++;
         repeat (PHASE_ITEMS) send_random();
      end
      quiet = 1'b0;
      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("text_screen_char_writer_top test passed");
      end else begin
         $display("text_screen_char_writer_top test failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/tscw_pkg.sv
rtl/core/tscw_cell_mem.sv
rtl/core/tscw_seq.sv
rtl/core/tscw_datapath.sv
rtl/core/text_screen_char_writer_top.sv
bench/text_screen_char_writer_checker.sv
bench/testbench.sv
